### rtl/assert_macros.svh
// assertion macros for the rtl modules
// no dependencies; expects clk and rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/mma_pkg.sv
// shared types, constants and helpers for the multichannel moving average
// no dependencies
package mma_pkg;

    localparam int SAMPLE_W = 12;
    localparam int CH_W     = 4;
    localparam int MUX_W    = 2;

    // analog multiplexer select codes
    localparam logic [MUX_W-1:0] MUX_LOW  = 2'd0;
    localparam logic [MUX_W-1:0] MUX_MID  = 2'd1;
    localparam logic [MUX_W-1:0] MUX_HIGH = 2'd2;

    // control handed from the sequencer to the row of channel cells
    typedef struct packed {
        logic                shift;
        logic [SAMPLE_W-1:0] sample;
    } mma_shift_t;

    // mux select for a channel; channels without a group keep the old code
    function automatic logic [MUX_W-1:0] mux_for(input logic [CH_W-1:0]  ch,
                                                 input logic [MUX_W-1:0] prev);
        logic [MUX_W-1:0] code;
        case (ch) inside
            [4'd0:4'd3]: code = MUX_LOW;
            [4'd4:4'd7]: code = MUX_MID;
            4'd8:        code = MUX_HIGH;
            default:     code = prev;
        endcase
        return code;
    endfunction

endpackage

### rtl/mma_cell.sv
// one channel slot: a ring of samples as a shift line plus its running sum
// depends on mma_pkg
module mma_cell
    import mma_pkg::*;
#(
    parameter int TAPS  = 8,
    parameter int SUM_W = 15
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mma_shift_t                 ctrl,
    input  logic                       insert,
    input  logic [TAPS*SAMPLE_W-1:0]   ring_in,
    input  logic [SUM_W-1:0]           sum_in,
    output logic [TAPS*SAMPLE_W-1:0]   ring,
    output logic [SUM_W-1:0]           sum
);

    logic [TAPS*SAMPLE_W-1:0] ring_reg;
    logic [TAPS*SAMPLE_W-1:0] ring_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [TAPS*SAMPLE_W-1:0] ring_shifted;
    logic [SAMPLE_W-1:0]      oldest;

    // newest sample sits in the low slot, oldest in the top slot
    assign oldest = ring_in[(TAPS-1)*SAMPLE_W +: SAMPLE_W];

    generate
        if (TAPS == 1) begin : g_single
            assign ring_shifted = ctrl.sample;
        end
        else begin : g_multi
            assign ring_shifted = {ring_in[(TAPS-1)*SAMPLE_W-1:0], ctrl.sample};
        end
    endgenerate

    // either take the neighbor's slot as is or fold the new sample into it
    always_comb
    begin
        if (insert)
        begin
            ring_next = ring_shifted;
            sum_next  = sum_in - SUM_W'(oldest) + SUM_W'(ctrl.sample);
        end
        else
        begin
            ring_next = ring_in;
            sum_next  = sum_in;
        end
    end

    // slot moves one place along the row on every transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= '0;
            sum_reg  <= '0;
        end
        else if (ctrl.shift)
        begin
            ring_reg <= ring_next;
            sum_reg  <= sum_next;
        end
    end

    assign ring = ring_reg;
    assign sum  = sum_reg;

endmodule

### rtl/mma_chain.sv
// rotating row of channel cells; the head cell always holds the current channel
// depends on mma_pkg and mma_cell
module mma_chain
    import mma_pkg::*;
#(
    parameter int CHANNELS = 9,
    parameter int TAPS     = 8,
    parameter int SUM_W    = 15
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  mma_shift_t       ctrl,
    output logic [SUM_W-1:0] last_sum
);

    logic [TAPS*SAMPLE_W-1:0] ring_q [CHANNELS];
    logic [SUM_W-1:0]         sum_q  [CHANNELS];

    // cell i loads from cell i+1; the tail loads from the head and folds in the new sample
    generate
        for (genvar i = 0; i < CHANNELS; i++)
        begin : g_cell
            localparam int SRC = (i + 1) % CHANNELS;

            mma_cell #(
                .TAPS  (TAPS),
                .SUM_W (SUM_W)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (ctrl),
                .insert  ((i == CHANNELS - 1) ? 1'b1 : 1'b0),
                .ring_in (ring_q[SRC]),
                .sum_in  (sum_q[SRC]),
                .ring    (ring_q[i]),
                .sum     (sum_q[i])
            );
        end
    endgenerate

    // tail holds the freshly updated channel right after a transfer
    assign last_sum = sum_q[CHANNELS-1];

endmodule

### rtl/multichannel_moving_average_adc.sv
// multichannel moving average: each transferred sample passes through stage one and then the
// output register, which result_stall can hold, before its result transfer
// throughput one sample per cycle while sample_stall is low; channel slots rotate through the cell row per transfer
// the tail cell's sum feeds one constant reciprocal multiply into the output register
// asynchronous active-low reset clears every ring and sum and the sequencer's channel and mux code at once
// no clearing pass after reset: samples are accepted straight away
`include "assert_macros.svh"

module multichannel_moving_average_adc
    import mma_pkg::*;
#(
    parameter int CHANNELS = 9,
    parameter int TAPS     = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                result_valid,
    input  logic                result_stall,
    output logic [CH_W-1:0]     channel,
    output logic [SAMPLE_W-1:0] average,
    output logic [CH_W-1:0]     next_channel,
    output logic [MUX_W-1:0]    mux_code
);

    localparam int SUM_W  = SAMPLE_W + $clog2(TAPS);
    localparam int DIV_L  = $clog2(TAPS);
    localparam int DIV_K  = SUM_W + DIV_L;
    localparam int PROD_W = 2 * SUM_W + 1;
    // ceil(2^K / TAPS) gives an exact floor quotient for every SUM_W-bit sum
    localparam logic [SUM_W:0] DIV_M = (SUM_W+1)'(((64'd1 << DIV_K) + TAPS - 1) / TAPS);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

    logic                accept;
    logic                out_load;
    mma_shift_t          chain_ctrl;
    logic [SUM_W-1:0]    last_sum;
    logic [PROD_W-1:0]   product;

    logic [CH_W-1:0]     ch_reg;
    logic [CH_W-1:0]     ch_next;
    logic [MUX_W-1:0]    mux_reg;
    logic [MUX_W-1:0]    mux_next;

    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic [CH_W-1:0]     s1_ch_reg;
    logic [CH_W-1:0]     s1_nch_reg;
    logic [MUX_W-1:0]    s1_mux_reg;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [CH_W-1:0]     out_ch_reg;
    logic [SAMPLE_W-1:0] out_avg_reg;
    logic [CH_W-1:0]     out_nch_reg;
    logic [MUX_W-1:0]    out_mux_reg;

    // handshake: stage one empties into the output register unless that is stuck
    assign out_load     = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && out_valid_reg && result_stall;
    assign accept       = sample_valid && !sample_stall;

    // round-robin channel sequencer
    assign ch_next  = (ch_reg == CH_LAST) ? '0 : ch_reg + CH_W'(1);
    assign mux_next = mux_for(ch_next, mux_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ch_reg  <= '0;
            mux_reg <= MUX_LOW;
        end
        else if (accept)
        begin
            ch_reg  <= ch_next;
            mux_reg <= mux_next;
        end
    end

    // rotate the channel slots and fold the new sample in
    assign chain_ctrl.shift  = accept;
    assign chain_ctrl.sample = sample;

    mma_chain #(
        .CHANNELS (CHANNELS),
        .TAPS     (TAPS),
        .SUM_W    (SUM_W)
    ) u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (chain_ctrl),
        .last_sum (last_sum)
    );

    // stage one: channel info of the item whose sum sits in the tail cell
    assign s1_valid_next = accept ? 1'b1 : (out_load ? 1'b0 : s1_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ch_reg  <= ch_reg;
            s1_nch_reg <= ch_next;
            s1_mux_reg <= mux_next;
        end
    end

    // mean by multiplying with the reciprocal of the tap count
    assign product = PROD_W'(last_sum) * PROD_W'(DIV_M);

    // output register
    assign out_valid_next = out_load ? 1'b1 : (result_stall ? out_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ch_reg  <= s1_ch_reg;
            out_avg_reg <= product[DIV_K +: SAMPLE_W];
            out_nch_reg <= s1_nch_reg;
            out_mux_reg <= s1_mux_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign channel      = out_ch_reg;
    assign average      = out_avg_reg;
    assign next_channel = out_nch_reg;
    assign mux_code     = out_mux_reg;

    // checks
    `ASSERT_CLK(a_ch_range, ({1'b0, ch_reg} < (CH_W+1)'(CHANNELS)), "channel counter out of range")
    `ASSERT_CLK(a_accept_lands, (accept |=> s1_valid_reg), "transfer did not reach stage one")
    `ASSERT_CLK(a_next_follows, (out_valid_reg |-> ((out_ch_reg == CH_LAST) ? (out_nch_reg == '0) : (out_nch_reg == out_ch_reg + CH_W'(1)))), "next channel does not follow channel")
    `ASSERT_CLK(a_mux_low, ((out_valid_reg && out_nch_reg <= CH_W'(3)) |-> (out_mux_reg == MUX_LOW)), "wrong mux code for low group")
    `ASSERT_ALWAYS(a_reset_idle, (!rst_n |=> (!out_valid_reg && !s1_valid_reg)), "pipeline busy in reset")

endmodule
